@@ hw/rtl/vvgs_pkg.sv @@
// Package for the voxel view-gain scorer.
// Holds register indexes, class codes, reset values, the arctangent table and item types.
// No dependencies.
package vvgs_pkg;

   localparam logic [2:0] CSR_VOXEL_SIZE      = 3'd0;
   localparam logic [2:0] CSR_RAY_ANGLE_HORIZ = 3'd1;
   localparam logic [2:0] CSR_RAY_ANGLE_VERT  = 3'd2;
   localparam logic [2:0] CSR_MIN_IMPACT      = 3'd3;
   localparam logic [2:0] CSR_FRONTIER_WEIGHT = 3'd4;
   localparam logic [2:0] CSR_UNKNOWN_WEIGHT  = 3'd5;

   localparam logic [1:0] CLS_OCCUPIED = 2'd0;
   localparam logic [1:0] CLS_UNKNOWN  = 2'd1;

   localparam logic [15:0] RST_VOXEL_SIZE      = 16'd205;
   localparam logic [30:0] RST_RAY_ANGLE       = 31'd268435456;
   localparam logic [16:0] RST_MIN_IMPACT      = 17'd0;
   localparam logic [31:0] RST_FRONTIER_WEIGHT = 32'd0;
   localparam logic [31:0] RST_UNKNOWN_WEIGHT  = 32'd65536;

   localparam int CORDIC_ITERS = 28;
   localparam int ZQ_W         = 31;
   localparam int ANGLE_W      = 30;
   localparam int DEN_W        = 124;
   localparam int NUM_W        = 108;
   localparam int NW_W         = 32;
   localparam int GAIN_W       = 17;

   localparam logic [16:0] GAIN_ONE = 17'd65536;

   localparam logic [27:0] ATAN_TAB [CORDIC_ITERS] = '{
      28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
      28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
      28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
      28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64,
      28'd32, 28'd16, 28'd8, 28'd4, 28'd2
   };

   typedef struct packed {
      logic [1:0]  cls;
      logic        frontier;
      logic        dist_zero;
      logic [31:0] map_weight;
   } item_type;

   typedef struct packed {
      item_type          item;
      logic [DEN_W-1:0]  den;
   } cordic_tag_type;

   typedef struct packed {
      item_type item;
      logic     sat;
   } div1_tag_type;

   typedef struct packed {
      logic [1:0] cls;
      logic       frontier;
      logic       dist_zero;
      logic       sum_zero;
   } div2_tag_type;

endpackage

@@ hw/rtl/vvgs_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a side tag.
// Depends on nothing but its parameters.
module vvgs_sqrt #(
   parameter int RAD_W = 62,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [TAG_W-1:0]     out_tag
);
   localparam int STAGES = RAD_W / 2;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 3;

   logic              valid_ff [STAGES];
   logic [RAD_W-1:0]  rad_ff   [STAGES];
   logic [REM_W-1:0]  rem_ff   [STAGES];
   logic [ROOT_W-1:0] root_ff  [STAGES];
   logic [TAG_W-1:0]  tag_ff   [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic              valid_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [TAG_W-1:0]  tag_prev;
      logic [REM_W-1:0]  rem_shift;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rad_prev   = in_rad;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      always_comb begin
         rem_shift = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
         trial     = REM_W'({root_prev, 2'b01});
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         rad_ff[k]  <= rad_prev << 2;
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         tag_ff[k]  <= tag_prev;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];
endmodule

@@ hw/rtl/vvgs_cordic.sv @@
// Pipelined CORDIC vectoring unit giving the full voxel view angle in unsigned Q2.28.
// Depends on vvgs_pkg for the arctangent table and widths.
module vvgs_cordic
   import vvgs_pkg::*;
#(
   parameter int TAG_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [ZQ_W-1:0]    in_zq,
   input  logic [15:0]        in_vsize,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output logic [ANGLE_W-1:0] out_angle,
   output logic [TAG_W-1:0]   out_tag
);
   localparam int XY_W = 44;
   localparam int ANG_W = 31;

   function automatic logic [5:0] msb_pos(input logic [31:0] v);
      logic [5:0] pos;
      pos = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            pos = 6'(i);
         end
      end
      return pos;
   endfunction

   logic                    nrm_valid_ff;
   logic signed [XY_W-1:0]  nrm_x_ff;
   logic signed [XY_W-1:0]  nrm_y_ff;
   logic                    nrm_yzero_ff;
   logic [TAG_W-1:0]        nrm_tag_ff;

   logic [31:0] x0;
   logic [31:0] y0;
   logic [31:0] mx;
   logic [5:0]  shamt;

   always_comb begin
      x0    = {in_zq, 1'b0};
      y0    = 32'({in_vsize, 6'b0});
      mx    = (x0 >= y0) ? x0 : y0;
      shamt = 6'd40 - msb_pos(mx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrm_valid_ff <= 1'b0;
      end else begin
         nrm_valid_ff <= in_valid;
      end
      nrm_x_ff     <= XY_W'(x0) << shamt;
      nrm_y_ff     <= XY_W'(y0) << shamt;
      nrm_yzero_ff <= (in_vsize == 16'd0);
      nrm_tag_ff   <= in_tag;
   end

   logic                   it_valid_ff [CORDIC_ITERS];
   logic signed [XY_W-1:0] it_x_ff     [CORDIC_ITERS];
   logic signed [XY_W-1:0] it_y_ff     [CORDIC_ITERS];
   logic signed [ANG_W-1:0] it_ang_ff  [CORDIC_ITERS];
   logic                   it_yzero_ff [CORDIC_ITERS];
   logic [TAG_W-1:0]       it_tag_ff   [CORDIC_ITERS];

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      logic                    valid_prev;
      logic signed [XY_W-1:0]  x_prev;
      logic signed [XY_W-1:0]  y_prev;
      logic signed [ANG_W-1:0] ang_prev;
      logic                    yzero_prev;
      logic [TAG_W-1:0]        tag_prev;
      logic signed [XY_W-1:0]  xs;
      logic signed [XY_W-1:0]  ys;
      logic signed [ANG_W-1:0] step;

      if (i == 0) begin : g_first
         assign valid_prev = nrm_valid_ff;
         assign x_prev     = nrm_x_ff;
         assign y_prev     = nrm_y_ff;
         assign ang_prev   = '0;
         assign yzero_prev = nrm_yzero_ff;
         assign tag_prev   = nrm_tag_ff;
      end else begin : g_next
         assign valid_prev = it_valid_ff[i-1];
         assign x_prev     = it_x_ff[i-1];
         assign y_prev     = it_y_ff[i-1];
         assign ang_prev   = it_ang_ff[i-1];
         assign yzero_prev = it_yzero_ff[i-1];
         assign tag_prev   = it_tag_ff[i-1];
      end

      assign xs   = x_prev >>> i;
      assign ys   = y_prev >>> i;
      assign step = ANG_W'(ATAN_TAB[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            it_valid_ff[i] <= 1'b0;
         end else begin
            it_valid_ff[i] <= valid_prev;
         end
         if (y_prev > 0) begin
            it_x_ff[i]   <= x_prev + ys;
            it_y_ff[i]   <= y_prev - xs;
            it_ang_ff[i] <= ang_prev + step;
         end else begin
            it_x_ff[i]   <= x_prev - ys;
            it_y_ff[i]   <= y_prev + xs;
            it_ang_ff[i] <= ang_prev - step;
         end
         it_yzero_ff[i] <= yzero_prev;
         it_tag_ff[i]   <= tag_prev;
      end
   end

   logic                   out_valid_ff;
   logic [ANGLE_W-1:0]     out_angle_ff;
   logic [TAG_W-1:0]       out_tag_ff;
   logic signed [ANG_W-1:0] ang_last;

   assign ang_last = it_ang_ff[CORDIC_ITERS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= it_valid_ff[CORDIC_ITERS-1];
      end
      if (it_yzero_ff[CORDIC_ITERS-1] || ang_last[ANG_W-1]) begin
         out_angle_ff <= '0;
      end else begin
         out_angle_ff <= {ang_last[ANGLE_W-2:0], 1'b0};
      end
      out_tag_ff <= it_tag_ff[CORDIC_ITERS-1];
   end

   assign out_valid = out_valid_ff;
   assign out_angle = out_angle_ff;
   assign out_tag   = out_tag_ff;
endmodule

@@ hw/rtl/vvgs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// The numerator must be below the divisor shifted left by the quotient width.
module vvgs_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 33,
   parameter int QUO_W = 17,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);
   localparam int WIDE = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic             valid_ff [QUO_W];
   logic [NUM_W-1:0] rem_ff   [QUO_W];
   logic [DEN_W-1:0] den_ff   [QUO_W];
   logic [QUO_W-1:0] quo_ff   [QUO_W];
   logic [TAG_W-1:0] tag_ff   [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int SH = QUO_W - 1 - k;
      logic             valid_prev;
      logic [NUM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [WIDE-1:0]  rem_ext;
      logic [WIDE-1:0]  den_sh;
      logic             fits;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_num;
         assign den_prev   = in_den;
         assign quo_prev   = '0;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      assign rem_ext = WIDE'(rem_prev);
      assign den_sh  = WIDE'(den_prev) << SH;
      assign fits    = (rem_ext >= den_sh);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         rem_ff[k] <= fits ? NUM_W'(rem_ext - den_sh) : rem_prev;
         den_ff[k] <= den_prev;
         quo_ff[k] <= {quo_prev[QUO_W-2:0], fits};
         tag_ff[k] <= tag_prev;
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_tag   = tag_ff[QUO_W-1];
endmodule

@@ hw/rtl/voxel_view_gain_scorer_top.sv @@
// Voxel view-gain scorer, top level: registers, distance, weight and gain pipeline.
// Each start transfer gives one rsp_strobe cycle with its score; one item per cycle.
// Throughput is set by a fully pipelined square root, CORDIC and two restoring dividers.
// Reset is synchronous and clears all valid bits and loads the register reset values.
// busy is high only during reset; the receiver cannot stall.
module voxel_view_gain_scorer_top
   import vvgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [23:0] req_voxel_x,
   input  logic [23:0] req_voxel_y,
   input  logic [23:0] req_voxel_z,
   input  logic [23:0] req_origin_x,
   input  logic [23:0] req_origin_y,
   input  logic [23:0] req_origin_z,
   input  logic [1:0]  req_voxel_class,
   input  logic [31:0] req_map_weight,
   input  logic        req_is_frontier,
   output logic        rsp_strobe,
   output logic [31:0] rsp_score,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int RAD_W = 62;

   logic [15:0] voxel_size_ff;
   logic [30:0] ray_h_ff;
   logic [30:0] ray_v_ff;
   logic [16:0] min_impact_ff;
   logic [31:0] frontier_weight_ff;
   logic [31:0] unknown_weight_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         voxel_size_ff      <= RST_VOXEL_SIZE;
         ray_h_ff           <= RST_RAY_ANGLE;
         ray_v_ff           <= RST_RAY_ANGLE;
         min_impact_ff      <= RST_MIN_IMPACT;
         frontier_weight_ff <= RST_FRONTIER_WEIGHT;
         unknown_weight_ff  <= RST_UNKNOWN_WEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VOXEL_SIZE:      voxel_size_ff      <= csr_wdata[15:0];
            CSR_RAY_ANGLE_HORIZ: ray_h_ff           <= csr_wdata[30:0];
            CSR_RAY_ANGLE_VERT:  ray_v_ff           <= csr_wdata[30:0];
            CSR_MIN_IMPACT:      min_impact_ff      <= csr_wdata[16:0];
            CSR_FRONTIER_WEIGHT: frontier_weight_ff <= csr_wdata;
            CSR_UNKNOWN_WEIGHT:  unknown_weight_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Absolute coordinate differences.
   logic        s0_valid_ff;
   item_type    s0_item_ff;
   logic [24:0] s0_ad_ff [3];
   logic [24:0] ad_in    [3];
   logic [23:0] vox      [3];
   logic [23:0] org      [3];

   assign vox[0] = req_voxel_x;
   assign vox[1] = req_voxel_y;
   assign vox[2] = req_voxel_z;
   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [24:0] diff;
      assign diff     = $signed({vox[a][23], vox[a]}) - $signed({org[a][23], org[a]});
      assign ad_in[a] = diff[24] ? 25'(-diff) : 25'(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
      s0_item_ff.cls        <= req_voxel_class;
      s0_item_ff.frontier   <= req_is_frontier;
      s0_item_ff.dist_zero  <= 1'b0;
      s0_item_ff.map_weight <= req_map_weight;
      for (int i = 0; i < 3; i++) begin
         s0_ad_ff[i] <= ad_in[i];
      end
   end

   // Squares.
   logic        s1_valid_ff;
   item_type    s1_item_ff;
   logic [49:0] s1_sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_item_ff <= s0_item_ff;
      for (int i = 0; i < 3; i++) begin
         s1_sq_ff[i] <= s0_ad_ff[i] * s0_ad_ff[i];
      end
   end

   // Squared distance.
   logic        s2_valid_ff;
   item_type    s2_item_ff;
   logic [49:0] s2_d2_ff;
   logic [49:0] d2_in;

   assign d2_in = s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_item_ff.cls        <= s1_item_ff.cls;
      s2_item_ff.frontier   <= s1_item_ff.frontier;
      s2_item_ff.map_weight <= s1_item_ff.map_weight;
      s2_item_ff.dist_zero  <= (d2_in == 50'd0);
      s2_d2_ff              <= d2_in;
   end

   logic            sq_valid;
   logic [ZQ_W-1:0] sq_zq;
   item_type        sq_item;

   vvgs_sqrt #(
      .RAD_W (RAD_W),
      .TAG_W ($bits(item_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_rad    ({s2_d2_ff, 12'd0}),
      .in_tag    (s2_item_ff),
      .out_valid (sq_valid),
      .out_root  (sq_zq),
      .out_tag   (sq_item)
   );

   // Divisor rx * ry * zq^2 built from 31 by 31 partial products.
   logic            m1_valid_ff;
   item_type        m1_item_ff;
   logic [ZQ_W-1:0] m1_zq_ff;
   logic [61:0]     m1_u_ff;
   logic [61:0]     m1_v_ff;

   logic            m2_valid_ff;
   item_type        m2_item_ff;
   logic [ZQ_W-1:0] m2_zq_ff;
   logic [61:0]     m2_ll_ff;
   logic [61:0]     m2_lh_ff;
   logic [61:0]     m2_hl_ff;
   logic [61:0]     m2_hh_ff;

   logic             m3_valid_ff;
   item_type         m3_item_ff;
   logic [ZQ_W-1:0]  m3_zq_ff;
   logic [DEN_W-1:0] m3_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= sq_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
      m1_item_ff <= sq_item;
      m1_zq_ff   <= sq_zq;
      m1_u_ff    <= ray_h_ff * sq_zq;
      m1_v_ff    <= ray_v_ff * sq_zq;
      m2_item_ff <= m1_item_ff;
      m2_zq_ff   <= m1_zq_ff;
      m2_ll_ff   <= m1_u_ff[30:0] * m1_v_ff[30:0];
      m2_lh_ff   <= m1_u_ff[30:0] * m1_v_ff[61:31];
      m2_hl_ff   <= m1_u_ff[61:31] * m1_v_ff[30:0];
      m2_hh_ff   <= m1_u_ff[61:31] * m1_v_ff[61:31];
      m3_item_ff <= m2_item_ff;
      m3_zq_ff   <= m2_zq_ff;
      m3_den_ff  <= (DEN_W'(m2_hh_ff) << 62) + (DEN_W'(m2_lh_ff) << 31)
                  + (DEN_W'(m2_hl_ff) << 31) + DEN_W'(m2_ll_ff);
   end

   cordic_tag_type     cd_tag_in;
   cordic_tag_type     cd_tag;
   logic               cd_valid;
   logic [ANGLE_W-1:0] cd_angle;

   assign cd_tag_in.item = m3_item_ff;
   assign cd_tag_in.den  = m3_den_ff;

   vvgs_cordic #(
      .TAG_W ($bits(cordic_tag_type))
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m3_valid_ff),
      .in_zq     (m3_zq_ff),
      .in_vsize  (voxel_size_ff),
      .in_tag    (cd_tag_in),
      .out_valid (cd_valid),
      .out_angle (cd_angle),
      .out_tag   (cd_tag)
   );

   // Angle squared, then the saturation test for the weight quotient.
   logic           a2_valid_ff;
   cordic_tag_type a2_tag_ff;
   logic [59:0]    a2_sq_ff;

   logic             sat_valid_ff;
   div1_tag_type     sat_tag_ff;
   logic [NUM_W-1:0] sat_num_ff;
   logic [DEN_W-1:0] sat_den_ff;
   logic [NUM_W-1:0] num_in;

   assign num_in = {a2_sq_ff, 48'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         a2_valid_ff  <= 1'b0;
         sat_valid_ff <= 1'b0;
      end else begin
         a2_valid_ff  <= cd_valid;
         sat_valid_ff <= a2_valid_ff;
      end
      a2_tag_ff       <= cd_tag;
      a2_sq_ff        <= cd_angle * cd_angle;
      sat_tag_ff.item <= a2_tag_ff.item;
      sat_tag_ff.sat  <= (a2_tag_ff.den == '0)
                       || ({48'd0, num_in} >= {a2_tag_ff.den, 32'd0});
      sat_num_ff      <= num_in;
      sat_den_ff      <= a2_tag_ff.den;
   end

   logic            dv1_valid;
   logic [NW_W-1:0] dv1_quo;
   div1_tag_type    dv1_tag;

   vvgs_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (NW_W),
      .TAG_W ($bits(div1_tag_type))
   ) u_div_weight (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sat_valid_ff),
      .in_num    (sat_num_ff),
      .in_den    (sat_den_ff),
      .in_tag    (sat_tag_ff),
      .out_valid (dv1_valid),
      .out_quo   (dv1_quo),
      .out_tag   (dv1_tag)
   );

   // Gain numerator and denominator.
   logic            sm_valid_ff;
   div2_tag_type    sm_tag_ff;
   logic [47:0]     sm_num_ff;
   logic [32:0]     sm_sum_ff;
   logic [NW_W-1:0] nw;
   logic [32:0]     sum_in;

   assign nw     = dv1_tag.sat ? '1 : dv1_quo;
   assign sum_in = 33'(nw) + 33'(dv1_tag.item.map_weight);

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_valid_ff <= 1'b0;
      end else begin
         sm_valid_ff <= dv1_valid;
      end
      sm_tag_ff.cls       <= dv1_tag.item.cls;
      sm_tag_ff.frontier  <= dv1_tag.item.frontier;
      sm_tag_ff.dist_zero <= dv1_tag.item.dist_zero;
      sm_tag_ff.sum_zero  <= (sum_in == 33'd0);
      sm_num_ff           <= {nw, 16'd0};
      sm_sum_ff           <= sum_in;
   end

   logic              dv2_valid;
   logic [GAIN_W-1:0] dv2_quo;
   div2_tag_type      dv2_tag;

   vvgs_div #(
      .NUM_W (48),
      .DEN_W (33),
      .QUO_W (GAIN_W),
      .TAG_W ($bits(div2_tag_type))
   ) u_div_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sm_valid_ff),
      .in_num    (sm_num_ff),
      .in_den    (sm_sum_ff),
      .in_tag    (sm_tag_ff),
      .out_valid (dv2_valid),
      .out_quo   (dv2_quo),
      .out_tag   (dv2_tag)
   );

   // Score selection.
   logic              rsp_strobe_ff;
   logic [31:0]       rsp_score_ff;
   logic [GAIN_W-1:0] gain;
   logic [31:0]       score_in;

   always_comb begin
      if (dv2_tag.dist_zero) begin
         gain = GAIN_ONE;
      end else if (dv2_tag.sum_zero) begin
         gain = '0;
      end else begin
         gain = dv2_quo;
      end
      case (dv2_tag.cls)
         CLS_OCCUPIED: score_in = (gain > min_impact_ff) ? 32'(gain) : 32'd0;
         CLS_UNKNOWN:  score_in = (frontier_weight_ff != 32'd0 && dv2_tag.frontier)
                                ? frontier_weight_ff : unknown_weight_ff;
         default:      score_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv2_valid;
      end
      rsp_score_ff <= score_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_score  = rsp_score_ff;

`ifndef SYNTHESIS
   localparam int LATENCY = 3 + RAD_W / 2 + 3 + CORDIC_ITERS + 2 + 2 + NW_W + 1 + GAIN_W + 1;

   a_strobe_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching start transfer");

   a_other_class_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(start && !busy && req_voxel_class[1], LATENCY)
      |-> rsp_score == 32'd0)
      else $error("free or other voxel gave a nonzero score");

   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(start && !busy && req_voxel_class == CLS_OCCUPIED, LATENCY)
      |-> rsp_score <= 32'd65536)
      else $error("occupied voxel gain above one");
`endif
endmodule
